// ===== rtl/core/djs_pkg.sv =====
package djs_pkg;

    // command codes (carried in tuser)
    localparam logic [3:0] CMD_SUBMIT   = 4'd0;
    localparam logic [3:0] CMD_CANCEL   = 4'd1;
    localparam logic [3:0] CMD_STATUS   = 4'd2;
    localparam logic [3:0] CMD_SET_PRIO = 4'd3;
    localparam logic [3:0] CMD_PAUSE    = 4'd4;
    localparam logic [3:0] CMD_RESUME   = 4'd5;
    localparam logic [3:0] CMD_QUERY    = 4'd6;
    localparam logic [3:0] CMD_DISPATCH = 4'd7;
    localparam logic [3:0] CMD_FINISH   = 4'd8;

    // job states
    localparam logic [2:0] ST_QUEUED    = 3'd0;
    localparam logic [2:0] ST_RUNNING   = 3'd1;
    localparam logic [2:0] ST_COMPLETED = 3'd2;
    localparam logic [2:0] ST_FAILED    = 3'd3;
    localparam logic [2:0] ST_CANCELLED = 3'd4;

    // status codes
    localparam logic [1:0] RC_OK        = 2'd0;
    localparam logic [1:0] RC_NOT_FOUND = 2'd1;
    localparam logic [1:0] RC_FULL      = 2'd2;
    localparam logic [1:0] RC_NONE      = 2'd3;

    localparam logic [2:0] KIND_MAX = 3'd5;

    localparam int IN_DATA_W  = 88;
    localparam int CMD_W      = 4;
    localparam int OUT_DATA_W = 96;
    localparam int RES_W      = 90;

    // result item, lowest field last
    typedef struct packed {
        logic               paused;
        logic [31:0]        payload;
        logic [15:0]        dep_id;
        logic               has_dep;
        logic signed [15:0] prio;
        logic [2:0]         kind;
        logic [2:0]         state;
        logic [15:0]        id;
        logic [1:0]         status;
    } t_result;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_IMM,
        OP_TGT_RD,
        OP_TGT_APPLY,
        OP_SCAN_START,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_SCAN_DEP,
        OP_BEST_RD
    } t_dp_op;

    typedef enum logic [1:0] {
        PATH_IMM,
        PATH_TGT,
        PATH_SCAN
    } t_path;

    typedef struct packed {
        t_path path;
        logic  out_busy;
        logic  need_dep;
        logic  scan_last;
        logic  best_v;
    } t_dp_stat;

endpackage

// ===== rtl/core/dependency_aware_job_scheduler.sv =====
// submit, pause, resume, query, misses and blocked dispatch answer from the decode state; cancel,
// status, set priority and finish first read the job's row and state
// dispatch walks the used slots, reading and checking each and fetching the state of a dependency
// when one is looked up, then reads the best slot when a job starts
// one item at a time, ready only while idle; an item taken while the last
// result waits is held until that result drains. reset: synchronous active low, clears fill
// count, pause, active job, id to 1
module dependency_aware_job_scheduler #(
    parameter int MAX_JOBS = 16,
    parameter int ID_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // job_id[15:0] job_kind[18:16] priority_req[34:19] has_dependency[35]
    // dependency_id[51:36] payload_handle[83:52] exit_ok[84]
    input  logic [djs_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // command[3:0]
    input  logic [djs_pkg::CMD_W-1:0]            i_s_axis_tuser,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // status_code[1:0] result_id[17:2] result_state[20:18] result_kind[23:21]
    // result_priority[39:24] result_has_dependency[40] result_dependency_id[56:41]
    // result_payload[88:57] paused_flag[89]
    output logic [djs_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready
);
    import djs_pkg::*;

    // sequencer issues one datapath op per cycle and steers on its status
    t_dp_op   op;
    t_dp_stat stat;

    djs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_op       (op)
    );

    // job table memories, counters, priority search and output register
    djs_datapath #(
        .MAX_JOBS (MAX_JOBS),
        .ID_BITS  (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_stat      (stat),
        .i_in_data   (i_s_axis_tdata),
        .i_in_cmd    (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// ===== rtl/core/djs_ram.sv =====
module djs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/djs_ctrl.sv =====
module djs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  djs_pkg::t_dp_stat i_stat,
    output djs_pkg::t_dp_op   o_op
);
    import djs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TGT_APPLY,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_DEP,
        S_SCAN_END
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.out_busy) begin
                    case (i_stat.path)
                        PATH_TGT: begin
                            o_op    = OP_TGT_RD;
                            n_state = S_TGT_APPLY;
                        end
                        PATH_SCAN: begin
                            o_op    = OP_SCAN_START;
                            n_state = S_SCAN_RD;
                        end
                        default: begin
                            o_op    = OP_IMM;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_TGT_APPLY: begin
                o_op    = OP_TGT_APPLY;
                n_state = S_IDLE;
            end
            S_SCAN_RD: begin
                o_op    = OP_SCAN_RD;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_op = OP_SCAN_CHK;
                if (i_stat.need_dep) begin
                    n_state = S_SCAN_DEP;
                end else if (i_stat.scan_last) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_DEP: begin
                o_op    = OP_SCAN_DEP;
                n_state = i_stat.scan_last ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END: begin
                if (i_stat.best_v) begin
                    o_op    = OP_BEST_RD;
                    n_state = S_TGT_APPLY;
                end else begin
                    o_op    = OP_IMM;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/core/djs_datapath.sv =====
module djs_datapath #(
    parameter int MAX_JOBS = 16,
    parameter int ID_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  djs_pkg::t_dp_op                  i_op,
    output djs_pkg::t_dp_stat                o_stat,
    input  logic [djs_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic [djs_pkg::CMD_W-1:0]        i_in_cmd,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [djs_pkg::OUT_DATA_W-1:0]   o_out_data
);
    import djs_pkg::*;

    localparam int SLOT_W = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int ROW_W  = ID_BITS + 68;

    // latched item
    logic [3:0]         r_cmd;
    logic [15:0]        r_job_id;
    logic [2:0]         r_kind;
    logic [15:0]        r_prio;
    logic               r_hasdep;
    logic [15:0]        r_depid;
    logic [31:0]        r_payload;
    logic               r_exit_ok;

    // scheduler state
    logic [CNT_W-1:0]   r_used, n_used;
    logic [ID_BITS-1:0] r_id_ctr, n_id_ctr;
    logic               r_paused, n_paused;
    logic               r_act_v, n_act_v;
    logic [SLOT_W-1:0]  r_act_slot, n_act_slot;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic [SLOT_W-1:0]  r_best, n_best;
    logic               r_best_v, n_best_v;
    logic signed [15:0] r_best_prio, n_best_prio;
    logic [SLOT_W-1:0]  r_tgt, n_tgt;
    logic               r_out_v, n_out_v;
    t_result            r_out, n_out;

    // memories
    logic               row_we, st_we, row_re, st_re;
    logic [SLOT_W-1:0]  row_waddr, st_waddr, row_raddr, st_raddr;
    logic [ROW_W-1:0]   row_wdata, row_rdata;
    logic [2:0]         st_wdata, st_rdata;

    // fields of the row read
    logic [ID_BITS-1:0] rd_id;
    logic [2:0]         rd_kind;
    logic [15:0]        rd_prio;
    logic               rd_hasdep;
    logic [15:0]        rd_depid;
    logic [31:0]        rd_payload;

    logic [SLOT_W:0]    job_lk, dep_lk;
    logic [2:0]         sub_kind;
    logic               elig;
    t_result            rep;

    // ids are handed out in slot order, so the first slot holding an id is id-1
    function automatic logic [SLOT_W:0] f_lookup(input logic [15:0] id,
                                                 input logic [CNT_W-1:0] used);
        logic [15:0] m1;
        logic        ok;
        m1 = id - 16'd1;
        ok = (id != 16'd0) && (33'(id) < (33'd1 << ID_BITS)) && (m1 < 16'(used));
        return {ok, m1[SLOT_W-1:0]};
    endfunction

    djs_ram #(.WIDTH(ROW_W), .DEPTH(MAX_JOBS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    djs_ram #(.WIDTH(3), .DEPTH(MAX_JOBS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign rd_payload = row_rdata[31:0];
    assign rd_depid   = row_rdata[47:32];
    assign rd_hasdep  = row_rdata[48];
    assign rd_prio    = row_rdata[64:49];
    assign rd_kind    = row_rdata[67:65];
    assign rd_id      = row_rdata[ROW_W-1:68];

    assign job_lk   = f_lookup(r_job_id, r_used);
    assign dep_lk   = f_lookup(rd_depid, r_used);
    assign sub_kind = (r_kind > KIND_MAX) ? 3'd0 : r_kind;

    always_comb begin
        rep         = '0;
        rep.id      = 16'(rd_id);
        rep.state   = st_rdata;
        rep.kind    = rd_kind;
        rep.prio    = rd_prio;
        rep.has_dep = rd_hasdep;
        rep.dep_id  = rd_depid;
        rep.payload = rd_payload;
    end

    // status toward the controller
    always_comb begin
        o_stat.out_busy  = r_out_v;
        o_stat.best_v    = r_best_v;
        o_stat.scan_last = (CNT_W'(r_idx) == r_used - CNT_W'(1));
        o_stat.need_dep  = (st_rdata == ST_QUEUED) && rd_hasdep && dep_lk[SLOT_W];
        case (r_cmd)
            CMD_CANCEL, CMD_STATUS, CMD_SET_PRIO: begin
                o_stat.path = job_lk[SLOT_W] ? PATH_TGT : PATH_IMM;
            end
            CMD_FINISH: begin
                o_stat.path = r_act_v ? PATH_TGT : PATH_IMM;
            end
            CMD_DISPATCH: begin
                o_stat.path = (r_paused || r_act_v || r_used == '0) ? PATH_IMM : PATH_SCAN;
            end
            default: begin
                o_stat.path = PATH_IMM;
            end
        endcase
    end

    always_comb begin
        n_used      = r_used;
        n_id_ctr    = r_id_ctr;
        n_paused    = r_paused;
        n_act_v     = r_act_v;
        n_act_slot  = r_act_slot;
        n_idx       = r_idx;
        n_best      = r_best;
        n_best_v    = r_best_v;
        n_best_prio = r_best_prio;
        n_tgt       = r_tgt;
        n_out_v     = r_out_v && !i_out_ready;
        n_out       = r_out;
        row_we      = 1'b0;
        st_we       = 1'b0;
        row_re      = 1'b0;
        st_re       = 1'b0;
        row_waddr   = r_tgt;
        st_waddr    = r_tgt;
        row_wdata   = row_rdata;
        st_wdata    = st_rdata;
        row_raddr   = r_idx;
        st_raddr    = r_idx;
        elig        = 1'b0;

        case (i_op)
            OP_IMM: begin
                n_out_v    = 1'b1;
                n_out      = '0;
                n_out.status = RC_NOT_FOUND;
                case (r_cmd)
                    CMD_SUBMIT: begin
                        if (r_used == CNT_W'(MAX_JOBS)) begin
                            n_out.status = RC_FULL;
                        end else begin
                            row_we    = 1'b1;
                            st_we     = 1'b1;
                            row_waddr = SLOT_W'(r_used);
                            st_waddr  = SLOT_W'(r_used);
                            row_wdata = {r_id_ctr, sub_kind, r_prio, r_hasdep, r_depid,
                                         r_payload};
                            st_wdata  = ST_QUEUED;
                            n_used    = r_used + CNT_W'(1);
                            n_id_ctr  = r_id_ctr + ID_BITS'(1);
                            if (n_id_ctr == '0) begin
                                n_id_ctr = ID_BITS'(1);
                            end
                            n_out.status  = RC_OK;
                            n_out.id      = 16'(r_id_ctr);
                            n_out.state   = ST_QUEUED;
                            n_out.kind    = sub_kind;
                            n_out.prio    = r_prio;
                            n_out.has_dep = r_hasdep;
                            n_out.dep_id  = r_depid;
                            n_out.payload = r_payload;
                        end
                    end
                    CMD_PAUSE: begin
                        n_paused     = 1'b1;
                        n_out.status = RC_OK;
                    end
                    CMD_RESUME: begin
                        n_paused     = 1'b0;
                        n_out.status = RC_OK;
                    end
                    CMD_QUERY: begin
                        n_out.status = RC_OK;
                    end
                    CMD_DISPATCH: begin
                        n_out.status = RC_NONE;
                    end
                    default: begin
                    end
                endcase
                n_out.paused = n_paused;
            end
            OP_TGT_RD: begin
                n_tgt     = (r_cmd == CMD_FINISH) ? r_act_slot : job_lk[SLOT_W-1:0];
                row_re    = 1'b1;
                st_re     = 1'b1;
                row_raddr = n_tgt;
                st_raddr  = n_tgt;
            end
            OP_BEST_RD: begin
                n_tgt     = r_best;
                row_re    = 1'b1;
                st_re     = 1'b1;
                row_raddr = r_best;
                st_raddr  = r_best;
            end
            OP_TGT_APPLY: begin
                n_out_v      = 1'b1;
                n_out        = '0;
                n_out.status = RC_NOT_FOUND;
                case (r_cmd)
                    CMD_CANCEL: begin
                        if (st_rdata == ST_QUEUED || st_rdata == ST_RUNNING) begin
                            st_we    = 1'b1;
                            st_wdata = ST_CANCELLED;
                            if (r_act_v && r_act_slot == r_tgt) begin
                                n_act_v = 1'b0;
                            end
                            n_out       = rep;
                            n_out.state = ST_CANCELLED;
                        end
                    end
                    CMD_STATUS: begin
                        n_out = rep;
                    end
                    CMD_SET_PRIO: begin
                        if (st_rdata == ST_QUEUED) begin
                            row_we    = 1'b1;
                            row_wdata = {rd_id, rd_kind, r_prio, rd_hasdep, rd_depid,
                                         rd_payload};
                            n_out      = rep;
                            n_out.prio = r_prio;
                        end
                    end
                    CMD_DISPATCH: begin
                        st_we       = 1'b1;
                        st_wdata    = ST_RUNNING;
                        n_act_v     = 1'b1;
                        n_act_slot  = r_tgt;
                        n_out       = rep;
                        n_out.state = ST_RUNNING;
                    end
                    CMD_FINISH: begin
                        st_we       = 1'b1;
                        st_wdata    = r_exit_ok ? ST_COMPLETED : ST_FAILED;
                        n_act_v     = 1'b0;
                        n_out       = rep;
                        n_out.state = st_wdata;
                    end
                    default: begin
                    end
                endcase
                n_out.paused = r_paused;
            end
            OP_SCAN_START: begin
                n_idx    = '0;
                n_best_v = 1'b0;
            end
            OP_SCAN_RD: begin
                row_re = 1'b1;
                st_re  = 1'b1;
            end
            OP_SCAN_CHK: begin
                if (o_stat.need_dep) begin
                    // fetch state of the job this one waits on
                    st_re    = 1'b1;
                    st_raddr = dep_lk[SLOT_W-1:0];
                end else begin
                    elig  = (st_rdata == ST_QUEUED);
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            OP_SCAN_DEP: begin
                elig  = (st_rdata == ST_COMPLETED);
                n_idx = r_idx + SLOT_W'(1);
            end
            default: begin
            end
        endcase

        // strict compare keeps the earliest slot on ties
        if (elig && (!r_best_v || $signed(rd_prio) > r_best_prio)) begin
            n_best_v    = 1'b1;
            n_best      = r_idx;
            n_best_prio = $signed(rd_prio);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_id_ctr   <= ID_BITS'(1);
            r_paused   <= 1'b0;
            r_act_v    <= 1'b0;
            r_act_slot <= '0;
            r_idx      <= '0;
            r_best_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_used     <= n_used;
            r_id_ctr   <= n_id_ctr;
            r_paused   <= n_paused;
            r_act_v    <= n_act_v;
            r_act_slot <= n_act_slot;
            r_idx      <= n_idx;
            r_best_v   <= n_best_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LATCH) begin
            r_cmd     <= i_in_cmd;
            r_job_id  <= i_in_data[15:0];
            r_kind    <= i_in_data[18:16];
            r_prio    <= i_in_data[34:19];
            r_hasdep  <= i_in_data[35];
            r_depid   <= i_in_data[51:36];
            r_payload <= i_in_data[83:52];
            r_exit_ok <= i_in_data[84];
        end
        r_best      <= n_best;
        r_best_prio <= n_best_prio;
        r_tgt       <= n_tgt;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = {(OUT_DATA_W - RES_W)'(0), r_out};

endmodule

// ===== tb/sv/dependency_aware_job_scheduler_test.sv =====
module dependency_aware_job_scheduler_test;
    import djs_pkg::*;

    localparam int NUM_SLOTS     = 16;
    localparam int RANDOM_ITEMS  = 830;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 200;

    // one command item as the sender sees it
    typedef struct {
        logic [3:0]         cmd;
        logic [15:0]        jid;
        logic [2:0]         kind;
        logic signed [15:0] prio;
        logic               has_dep;
        logic [15:0]        dep_id;
        logic [31:0]        payload;
        logic               exit_ok;
    } t_command;

    // job table mirror and the answers still owed by the block
    class job_table_scoreboard;
        logic               used [NUM_SLOTS];
        logic [15:0]        id [NUM_SLOTS];
        logic [2:0]         kind [NUM_SLOTS];
        logic [2:0]         state [NUM_SLOTS];
        logic signed [15:0] prio [NUM_SLOTS];
        logic               has_dep [NUM_SLOTS];
        logic [15:0]        dep_id [NUM_SLOTS];
        logic [31:0]        payload [NUM_SLOTS];
        int                 used_count;
        logic [15:0]        next_id;
        logic               paused;
        logic               busy;
        int                 busy_slot;
        t_result            owed [$];
        int                 errors;
        int                 results_seen;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) used[i] = 1'b0;
            used_count = 0;
            next_id    = 16'd1;
            paused     = 1'b0;
            busy       = 1'b0;
            busy_slot  = 0;
            errors     = 0;
            results_seen = 0;
        endfunction

        function int lookup(logic [15:0] jid);
            for (int i = 0; i < NUM_SLOTS; i++)
                if (used[i] && id[i] == jid) return i;
            return -1;
        endfunction

        function bit ready_to_run(int s);
            int d;
            if (!used[s] || state[s] != ST_QUEUED) return 0;
            if (!has_dep[s]) return 1;
            d = lookup(dep_id[s]);
            return d < 0 || state[d] == ST_COMPLETED;
        endfunction

        function void fill_job(ref t_result r, input int s);
            r.id      = id[s];
            r.state   = state[s];
            r.kind    = kind[s];
            r.prio    = prio[s];
            r.has_dep = has_dep[s];
            r.dep_id  = dep_id[s];
            r.payload = payload[s];
        endfunction

        // apply one accepted command and queue the answer it must produce
        function void note_command(t_command c);
            t_result r;
            int      s;
            r = '0;
            r.status = RC_NOT_FOUND;
            case (c.cmd)
                CMD_SUBMIT: begin
                    s = -1;
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (!used[i] && s < 0) s = i;
                    if (s < 0) begin
                        r.status = RC_FULL;
                    end else begin
                        used[s]    = 1'b1;
                        id[s]      = next_id;
                        kind[s]    = (c.kind > KIND_MAX) ? 3'd0 : c.kind;
                        state[s]   = ST_QUEUED;
                        prio[s]    = c.prio;
                        has_dep[s] = c.has_dep;
                        dep_id[s]  = c.dep_id;
                        payload[s] = c.payload;
                        used_count++;
                        next_id = next_id + 16'd1;
                        if (next_id == 16'd0) next_id = 16'd1;
                        r.status = RC_OK;
                        fill_job(r, s);
                    end
                end
                CMD_CANCEL: begin
                    s = lookup(c.jid);
                    if (s >= 0 && (state[s] == ST_QUEUED || state[s] == ST_RUNNING)) begin
                        state[s] = ST_CANCELLED;
                        if (busy && busy_slot == s) busy = 1'b0;
                        r.status = RC_OK;
                        fill_job(r, s);
                    end
                end
                CMD_STATUS: begin
                    s = lookup(c.jid);
                    if (s >= 0) begin
                        r.status = RC_OK;
                        fill_job(r, s);
                    end
                end
                CMD_SET_PRIO: begin
                    s = lookup(c.jid);
                    if (s >= 0 && state[s] == ST_QUEUED) begin
                        prio[s]  = c.prio;
                        r.status = RC_OK;
                        fill_job(r, s);
                    end
                end
                CMD_PAUSE: begin
                    paused = 1'b1;
                    r.status = RC_OK;
                end
                CMD_RESUME: begin
                    paused = 1'b0;
                    r.status = RC_OK;
                end
                CMD_QUERY: r.status = RC_OK;
                CMD_DISPATCH: begin
                    r.status = RC_NONE;
                    if (!paused && !busy) begin
                        s = -1;
                        // strict compare keeps the lowest slot on a tie
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (ready_to_run(i) && (s < 0 || prio[i] > prio[s])) s = i;
                        if (s >= 0) begin
                            state[s]  = ST_RUNNING;
                            busy      = 1'b1;
                            busy_slot = s;
                            r.status  = RC_OK;
                            fill_job(r, s);
                        end
                    end
                end
                CMD_FINISH: begin
                    if (busy) begin
                        state[busy_slot] = c.exit_ok ? ST_COMPLETED : ST_FAILED;
                        busy     = 1'b0;
                        r.status = RC_OK;
                        fill_job(r, busy_slot);
                    end
                end
                default: ;
            endcase
            r.paused = paused;
            owed = {owed, r};
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch on result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
        endtask

        task check_result(t_result got);
            t_result want;
            results_seen++;
            if (owed.size() == 0) begin
                report("unexpected result", 32'd1, 32'd0);
                return;
            end
            want = owed.pop_front();
            if (got.status  !== want.status)  report("status",  got.status,  want.status);
            if (got.id      !== want.id)      report("id",      got.id,      want.id);
            if (got.state   !== want.state)   report("state",   got.state,   want.state);
            if (got.kind    !== want.kind)    report("kind",    got.kind,    want.kind);
            if (got.prio    !== want.prio)    report("prio",    got.prio,    want.prio);
            if (got.has_dep !== want.has_dep) report("has_dep", got.has_dep, want.has_dep);
            if (got.dep_id  !== want.dep_id)  report("dep_id",  got.dep_id,  want.dep_id);
            if (got.payload !== want.payload) report("payload", got.payload, want.payload);
            if (got.paused  !== want.paused)  report("paused",  got.paused,  want.paused);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;   // job_id, job_kind, priority_req, has_dependency,
                                             // dependency_id, payload_handle, exit_ok
    logic [CMD_W-1:0]      i_s_axis_tuser;   // command
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // status_code, result_id, result_state, result_kind,
                                             // result_priority, result_has_dependency,
                                             // result_dependency_id, result_payload, paused_flag
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;

    job_table_scoreboard board;
    int  send_idle_pct;      // chance per cycle that the sender waits
    int  recv_stall_pct;     // chance per cycle that the receiver holds off
    bit  hold_request;       // asks the receiver for one long hold-off
    int  cycle_count;

    dependency_aware_job_scheduler DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(t_result'(o_m_axis_tdata[RES_W-1:0]));
    end

    // receiver ready, random stalls plus the one long hold-off
    initial begin
        int held;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_m_axis_tready = 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge i_clk);
                hold_request = 0;
            end
            i_m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one item and wait until the block takes it
    task automatic send_command(t_command c);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tdata  = {3'b000, c.exit_ok, c.payload, c.dep_id, c.has_dep,
                           c.prio, c.kind, c.jid};
        i_s_axis_tuser  = c.cmd;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_command(c);
    endtask

    function automatic t_command noise_command(logic [3:0] cmd);
        t_command c;
        c.cmd     = cmd;
        c.jid     = 16'($urandom);
        c.kind    = 3'($urandom);
        c.prio    = 16'($urandom);
        c.has_dep = 1'($urandom);
        c.dep_id  = 16'($urandom);
        c.payload = 32'($urandom);
        c.exit_ok = 1'($urandom);
        return c;
    endfunction

    task automatic send_op(logic [3:0] cmd, logic [15:0] jid, logic signed [15:0] prio,
                           logic [2:0] kind, logic has_dep, logic [15:0] dep_id,
                           logic [31:0] payload, logic exit_ok);
        t_command c;
        c = '{cmd, jid, kind, prio, has_dep, dep_id, payload, exit_ok};
        send_command(c);
    endtask

    // a job id that mostly names an existing or nearly existing job
    function automatic logic [15:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 80) return 16'($urandom_range(board.next_id, 1));
        if (r < 85) return 16'd0;
        if (r < 90) return 16'hffff;
        return 16'($urandom);
    endfunction

    function automatic t_command random_command();
        t_command c;
        int       r;
        c = noise_command(CMD_QUERY);
        c.jid = pick_id();
        r = $urandom_range(99);
        // submits are kept rare so the table fills over the whole run
        if (r < 4) begin
            c.cmd = CMD_SUBMIT;
            c.dep_id = pick_id();
            if ($urandom_range(9) == 0) c.dep_id = board.next_id;  // self dependency
        end
        else if (r < 28) c.cmd = CMD_DISPATCH;
        else if (r < 46) c.cmd = CMD_FINISH;
        else if (r < 62) c.cmd = CMD_STATUS;
        else if (r < 72) c.cmd = CMD_CANCEL;
        else if (r < 82) c.cmd = CMD_SET_PRIO;
        else if (r < 86) c.cmd = CMD_PAUSE;
        else if (r < 93) c.cmd = CMD_RESUME;
        else if (r < 96) c.cmd = CMD_QUERY;
        else c.cmd = 4'($urandom_range(15, 9));
        return c;
    endfunction

    initial begin
        int phase;
        board           = new();
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_request    = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_QUERY;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: pause handling, empty table, misses and unknown command
        send_op(CMD_QUERY,    16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_PAUSE,    16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_DISPATCH, 16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_RESUME,   16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_DISPATCH, 16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_FINISH,   16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b1);
        send_op(4'd15,        16'hffff, -16'sd1, 3'd7, 1'b1, 16'hffff, 32'hffffffff, 1'b1);
        send_op(CMD_STATUS,   16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        // job 1 waits on itself, job 2 waits on job 3, out of range kind stored as zero
        send_op(CMD_SUBMIT, 16'd0, -16'sd32768, 3'd7, 1'b1, 16'd1, 32'd0, 1'b0);
        send_op(CMD_SUBMIT, 16'hffff, 16'sd32767, 3'd5, 1'b1, 16'd3, 32'hffffffff, 1'b1);
        send_op(CMD_SUBMIT, 16'd0, 16'sd100, 3'd6, 1'b0, 16'hffff, 32'h5a5a_a5a5, 1'b0);
        send_op(CMD_SET_PRIO, 16'd3, 16'sd32767, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_DISPATCH, 16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_DISPATCH, 16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        // cancelling the running job ends it
        send_op(CMD_CANCEL,   16'd3, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_FINISH,   16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b1);
        send_op(CMD_DISPATCH, 16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        // equal priorities: the earlier entry wins
        send_op(CMD_SUBMIT, 16'd0, 16'sd0, 3'd1, 1'b0, 16'd0, 32'h1234_5678, 1'b0);
        send_op(CMD_SUBMIT, 16'd0, 16'sd0, 3'd2, 1'b0, 16'd0, 32'h8765_4321, 1'b0);
        send_op(CMD_DISPATCH, 16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_FINISH,   16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b1);
        send_op(CMD_CANCEL,   16'd4, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_SET_PRIO, 16'd4, 16'sd5, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_DISPATCH, 16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);
        send_op(CMD_FINISH,   16'd0, 16'sd0, 3'd0, 1'b0, 16'd0, 32'd0, 1'b0);

        // random part in four idling phases, long hold-off early on
        hold_request = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase = n * 4 / RANDOM_ITEMS;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            // once the table is full, keep refilling is pointless; still probe table full
            send_command(random_command());
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
